// ===== rtl/tcb_pkg.sv =====
package tcb_pkg;

	// Default console geometry limits
	localparam int MAX_COLS_DEF = 128;
	localparam int MAX_ROWS_DEF = 64;

	localparam logic [7:0] SPACE = 8'h20;

	// Operation codes
	localparam logic [2:0] OP_CLEAR = 3'd0;
	localparam logic [2:0] OP_SET   = 3'd1;
	localparam logic [2:0] OP_PUT   = 3'd2;
	localparam logic [2:0] OP_GET   = 3'd3;
	localparam logic [2:0] OP_PRINT = 3'd4;
	localparam logic [2:0] OP_SHIFT = 3'd5;

	// Shift direction bits
	localparam logic [3:0] DIR_UP    = 4'd1;
	localparam logic [3:0] DIR_RIGHT = 4'd2;
	localparam logic [3:0] DIR_DOWN  = 4'd4;
	localparam logic [3:0] DIR_LEFT  = 4'd8;

	// Register file
	localparam int         APB_ADDR_W    = 3;
	localparam int         APB_DATA_W    = 32;
	localparam logic       REG_COLUMNS   = 1'b0;
	localparam logic       REG_ROWS      = 1'b1;
	localparam logic [7:0] COLUMNS_RESET = 8'd80;
	localparam logic [6:0] ROWS_RESET    = 7'd25;

	// Store walk kinds
	localparam logic [1:0] K_INIT  = 2'd0;
	localparam logic [1:0] K_CLEAR = 2'd1;
	localparam logic [1:0] K_EDGE  = 2'd2;
	localparam logic [1:0] K_MOVE  = 2'd3;

	// Shift phases
	localparam logic [1:0] PH_UP    = 2'd0;
	localparam logic [1:0] PH_DOWN  = 2'd1;
	localparam logic [1:0] PH_LEFT  = 2'd2;
	localparam logic [1:0] PH_RIGHT = 2'd3;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] col;
		logic [7:0] row;
		logic [7:0] char_in;
		logic [3:0] direction;
		logic       roll;
	} req_t;

	typedef struct packed {
		logic [7:0] read_char;
		logic [7:0] cursor_col;
		logic [7:0] cursor_row;
	} rsp_t;

	// Controller to datapath commands
	typedef struct packed {
		logic       capture;
		logic       cur_set;
		logic       cur_clear;
		logic       cur_advance;
		logic       mul_en;
		logic       mul_area;
		logic       cell_access;
		logic       walk_load;
		logic       walk_step;
		logic [1:0] kind;
		logic [1:0] phase;
	} ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic [2:0] op;
		logic [3:0] dir;
		logic       roll;
		logic       walk_last;
	} sts_t;

	function automatic logic shift_code_ok(input logic [3:0] dir);
		return (dir == DIR_UP) || (dir == DIR_RIGHT) || (dir == (DIR_UP | DIR_RIGHT)) ||
			(dir == DIR_DOWN) || (dir == (DIR_DOWN | DIR_RIGHT)) || (dir == DIR_LEFT) ||
			(dir == (DIR_DOWN | DIR_LEFT)) || (dir == (DIR_UP | DIR_LEFT));
	endfunction

endpackage

// ===== rtl/tcb_ctrl.sv =====
module tcb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          out_free,
	input  tcb_pkg::sts_t sts,
	output tcb_pkg::ctl_t ctl,
	output logic          idle,
	output logic          out_load
);
	import tcb_pkg::*;

	localparam logic [3:0] S_INIT   = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_DECODE = 4'd2;
	localparam logic [3:0] S_ACC    = 4'd3;
	localparam logic [3:0] S_AREA   = 4'd4;
	localparam logic [3:0] S_CLEAR  = 4'd5;
	localparam logic [3:0] S_EDGE   = 4'd6;
	localparam logic [3:0] S_MOVE   = 4'd7;
	localparam logic [3:0] S_FLUSH  = 4'd8;
	localparam logic [3:0] S_DONE   = 4'd9;

	logic [3:0] state_q, state_d;
	logic [1:0] phase_q, phase_d;
	logic       after_edge_q, after_edge_d;
	logic       has_vert, has_horiz, vert_q;
	logic [1:0] vphase, hphase;

	// Phase selection from the shift code
	assign has_vert  = sts.dir[0] | sts.dir[2];
	assign has_horiz = sts.dir[1] | sts.dir[3];
	assign vphase    = sts.dir[0] ? PH_UP : PH_DOWN;
	assign hphase    = sts.dir[3] ? PH_LEFT : PH_RIGHT;
	assign vert_q    = (phase_q == PH_UP) || (phase_q == PH_DOWN);

	// Next state and commands
	always_comb begin
		ctl          = '0;
		state_d      = state_q;
		phase_d      = phase_q;
		after_edge_d = after_edge_q;
		idle         = 1'b0;
		out_load     = 1'b0;
		unique case (state_q)
			S_INIT: begin
				ctl.kind      = K_INIT;
				ctl.walk_step = 1'b1;
				if (sts.walk_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				idle = 1'b1;
				if (req_valid) begin
					ctl.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (sts.op)
					OP_CLEAR: begin
						ctl.kind      = K_CLEAR;
						ctl.walk_load = 1'b1;
						state_d       = S_CLEAR;
					end
					OP_SET: begin
						ctl.cur_set = 1'b1;
						state_d     = S_DONE;
					end
					OP_PUT, OP_GET, OP_PRINT: begin
						ctl.mul_en = 1'b1;
						state_d    = S_ACC;
					end
					OP_SHIFT: begin
						if (shift_code_ok(sts.dir)) begin
							ctl.mul_en   = 1'b1;
							ctl.mul_area = 1'b1;
							state_d      = S_AREA;
						end else begin
							state_d = S_DONE;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_ACC: begin
				ctl.cell_access = 1'b1;
				ctl.cur_advance = (sts.op == OP_PRINT);
				state_d         = S_DONE;
			end
			S_AREA: begin
				phase_d       = has_vert ? vphase : hphase;
				ctl.walk_load = 1'b1;
				ctl.kind      = sts.roll ? K_EDGE : K_MOVE;
				state_d       = sts.roll ? S_EDGE : S_MOVE;
				after_edge_d  = sts.roll;
			end
			S_CLEAR: begin
				ctl.kind      = K_CLEAR;
				ctl.walk_step = 1'b1;
				if (sts.walk_last) begin
					ctl.cur_clear = 1'b1;
					state_d       = S_DONE;
				end
			end
			S_EDGE: begin
				ctl.kind      = K_EDGE;
				ctl.walk_step = 1'b1;
				if (sts.walk_last) state_d = S_FLUSH;
			end
			S_MOVE: begin
				ctl.kind      = K_MOVE;
				ctl.walk_step = 1'b1;
				after_edge_d  = 1'b0;
				if (sts.walk_last) state_d = S_FLUSH;
			end
			S_FLUSH: begin
				// last write of the pass lands here
				if (after_edge_q) begin
					ctl.kind      = K_MOVE;
					ctl.walk_load = 1'b1;
					after_edge_d  = 1'b0;
					state_d       = S_MOVE;
				end else if (vert_q && has_horiz) begin
					phase_d       = hphase;
					ctl.walk_load = 1'b1;
					ctl.kind      = sts.roll ? K_EDGE : K_MOVE;
					state_d       = sts.roll ? S_EDGE : S_MOVE;
					after_edge_d  = sts.roll;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		ctl.phase = phase_d;
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			phase_q      <= PH_UP;
			after_edge_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			phase_q      <= phase_d;
			after_edge_q <= after_edge_d;
		end
	end

endmodule

// ===== rtl/tcb_dp.sv =====
module tcb_dp #(
	parameter int MAX_COLS = tcb_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = tcb_pkg::MAX_ROWS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tcb_pkg::req_t req,
	input  logic [7:0]    columns,
	input  logic [6:0]    rows,
	input  tcb_pkg::ctl_t ctl,
	output tcb_pkg::sts_t sts,
	output tcb_pkg::rsp_t result
);
	import tcb_pkg::*;

	localparam int Depth     = MAX_COLS * MAX_ROWS;
	localparam int AW        = $clog2(Depth);
	localparam int EdgeDepth = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
	localparam int EW        = $clog2(EdgeDepth);
	localparam logic [AW-1:0] LastAddr = AW'(Depth - 1);

	// Effective geometry
	logic [7:0] c_eff, c_last;
	logic [6:0] r_eff, r_last;

	always_comb begin
		c_eff = columns;
		if (columns == 8'd0) c_eff = 8'd1;
		else if (int'(columns) > MAX_COLS) c_eff = 8'(MAX_COLS);
		r_eff = rows;
		if (rows == 7'd0) r_eff = 7'd1;
		else if (int'(rows) > MAX_ROWS) r_eff = 7'(MAX_ROWS);
	end
	assign c_last = c_eff - 8'd1;
	assign r_last = r_eff - 7'd1;

	// Captured transaction
	req_t item_q;
	always_ff @(posedge clk) begin
		if (ctl.capture) item_q <= req;
	end

	logic [7:0] cur_x_q, cur_y_q;
	logic is_print;
	logic [7:0] col_sel, row_sel;
	assign is_print = (item_q.operation == OP_PRINT);
	assign col_sel  = is_print ? cur_x_q : item_q.col;
	assign row_sel  = is_print ? cur_y_q : item_q.row;

	// Row times columns, registered
	logic [15:0] mul_q;
	logic [7:0]  mul_a;
	assign mul_a = ctl.mul_area ? {1'b0, r_eff} : row_sel;
	always_ff @(posedge clk) begin
		if (ctl.mul_en) mul_q <= 16'(mul_a) * 16'(c_eff);
	end

	// Single cell access
	logic [AW-1:0] cell_addr;
	logic          cell_hit, cell_wr, cell_rd;
	assign cell_addr = AW'(mul_q + 16'(col_sel));
	assign cell_hit  = (col_sel < c_eff) && (row_sel < {1'b0, r_eff});
	assign cell_wr   = ctl.cell_access && cell_hit &&
		((item_q.operation == OP_PUT) || is_print);
	assign cell_rd   = ctl.cell_access && cell_hit && (item_q.operation == OP_GET);

	// Cursor
	logic [8:0] adv_x, adv_y;
	logic       get_hit_q;

	always_comb begin
		adv_x = {1'b0, cur_x_q} + 9'd1;
		adv_y = {1'b0, cur_y_q};
		if (adv_x >= {1'b0, c_eff}) begin
			adv_x = 9'd0;
			adv_y = adv_y + 9'd1;
		end
		if (adv_y >= {2'b00, r_eff}) begin
			adv_x = 9'd0;
			adv_y = 9'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q   <= 8'd0;
			cur_y_q   <= 8'd0;
			get_hit_q <= 1'b0;
		end else begin
			priority if (ctl.cur_set) begin
				cur_x_q <= item_q.col;
				cur_y_q <= item_q.row;
			end else if (ctl.cur_clear) begin
				cur_x_q <= 8'd0;
				cur_y_q <= 8'd0;
			end else if (ctl.cur_advance) begin
				cur_x_q <= adv_x[7:0];
				cur_y_q <= adv_y[7:0];
			end
			if (ctl.capture) get_hit_q <= 1'b0;
			else if (ctl.cell_access) get_hit_q <= cell_rd;
		end
	end

	// Walker: address plus column and row counters
	logic [AW-1:0] addr_q, addr_d, area, c_aw, src, stride;
	logic [7:0]    x_q, x_d;
	logic [6:0]    y_q, y_d;
	logic          vert, asc, at_end, at_start, on_edge;
	logic [EW-1:0] eidx;

	assign area     = AW'(mul_q);
	assign c_aw     = AW'(c_eff);
	assign vert     = (ctl.phase == PH_UP) || (ctl.phase == PH_DOWN);
	assign asc      = (ctl.phase == PH_UP) || (ctl.phase == PH_LEFT);
	assign at_end   = (x_q == c_last) && (y_q == r_last);
	assign at_start = (x_q == 8'd0) && (y_q == 7'd0);
	assign stride   = vert ? AW'(1) : c_aw;
	assign eidx     = vert ? EW'(x_q) : EW'(y_q);

	always_comb begin
		unique case (ctl.phase)
			PH_UP: begin
				src     = addr_q + c_aw;
				on_edge = (y_q == r_last);
			end
			PH_DOWN: begin
				src     = addr_q - c_aw;
				on_edge = (y_q == 7'd0);
			end
			PH_LEFT: begin
				src     = addr_q + AW'(1);
				on_edge = (x_q == c_last);
			end
			default: begin
				src     = addr_q - AW'(1);
				on_edge = (x_q == 8'd0);
			end
		endcase
	end

	// Walker next values
	always_comb begin
		addr_d = addr_q;
		x_d    = x_q;
		y_d    = y_q;
		if (ctl.walk_load) begin
			addr_d = '0;
			x_d    = 8'd0;
			y_d    = 7'd0;
			if (ctl.kind == K_EDGE) begin
				unique case (ctl.phase)
					PH_DOWN:  addr_d = area - c_aw;
					PH_RIGHT: addr_d = c_aw - AW'(1);
					default:  addr_d = '0;
				endcase
			end else if (ctl.kind == K_MOVE && !asc) begin
				addr_d = area - AW'(1);
				x_d    = c_last;
				y_d    = r_last;
			end
		end else if (ctl.walk_step) begin
			unique case (ctl.kind)
				K_INIT: addr_d = addr_q + AW'(1);
				K_EDGE: begin
					addr_d = addr_q + stride;
					x_d    = x_q + 8'd1;
				end
				default: begin
					if (ctl.kind == K_MOVE && !asc) begin
						addr_d = addr_q - AW'(1);
						if (x_q == 8'd0) begin
							x_d = c_last;
							y_d = y_q - 7'd1;
						end else begin
							x_d = x_q - 8'd1;
						end
					end else begin
						addr_d = addr_q + AW'(1);
						if (x_q == c_last) begin
							x_d = 8'd0;
							y_d = y_q + 7'd1;
						end else begin
							x_d = x_q + 8'd1;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			x_q    <= 8'd0;
			y_q    <= 7'd0;
		end else begin
			addr_q <= addr_d;
			x_q    <= x_d;
			y_q    <= y_d;
		end
	end

	// Last step of the current walk
	logic walk_last;
	always_comb begin
		unique case (ctl.kind)
			K_INIT:  walk_last = (addr_q == LastAddr);
			K_CLEAR: walk_last = at_end;
			K_EDGE:  walk_last = (x_q == (vert ? c_last : {1'b0, r_last}));
			default: walk_last = asc ? at_end : at_start;
		endcase
	end
	assign sts = {item_q.operation, item_q.direction, item_q.roll, walk_last};

	// Pass pipeline: read this cycle, write back next cycle
	logic          step_fill, step_edge, step_move;
	logic          mv_s1, eg_s1, edge_s1;
	logic [AW-1:0] addr_s1;
	logic [EW-1:0] idx_s1;

	assign step_fill = ctl.walk_step && ((ctl.kind == K_INIT) || (ctl.kind == K_CLEAR));
	assign step_edge = ctl.walk_step && (ctl.kind == K_EDGE);
	assign step_move = ctl.walk_step && (ctl.kind == K_MOVE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_s1 <= 1'b0;
			eg_s1 <= 1'b0;
		end else begin
			mv_s1 <= step_move;
			eg_s1 <= step_edge;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr_q;
		edge_s1 <= on_edge;
		idx_s1  <= step_edge ? EW'(x_q) : eidx;
	end

	// Store and edge line ports
	logic [7:0]    store_mem [Depth];
	logic [7:0]    edge_mem [EdgeDepth];
	logic [7:0]    rd_q, edge_rd_q, st_wdata;
	logic [AW-1:0] st_waddr, st_raddr;
	logic          st_we, st_re, ed_re;

	always_comb begin
		st_we    = 1'b1;
		st_waddr = addr_q;
		st_wdata = SPACE;
		priority if (mv_s1) begin
			st_waddr = addr_s1;
			st_wdata = edge_s1 ? (item_q.roll ? edge_rd_q : SPACE) : rd_q;
		end else if (step_fill) begin
			st_waddr = addr_q;
		end else if (cell_wr) begin
			st_waddr = cell_addr;
			st_wdata = item_q.char_in;
		end else begin
			st_we = 1'b0;
		end
	end

	assign st_re    = cell_rd || step_edge || (step_move && !on_edge);
	assign st_raddr = cell_rd ? cell_addr : (step_edge ? addr_q : src);
	assign ed_re    = step_move && on_edge && item_q.roll;

	always_ff @(posedge clk) begin
		if (st_we) store_mem[st_waddr] <= st_wdata;
		if (st_re) rd_q <= store_mem[st_raddr];
		if (eg_s1) edge_mem[idx_s1] <= rd_q;
		if (ed_re) edge_rd_q <= edge_mem[eidx];
	end

	// Result of the transaction
	always_comb begin
		result.read_char  = get_hit_q ? rd_q : SPACE;
		result.cursor_col = cur_x_q;
		result.cursor_row = cur_y_q;
	end

endmodule

// ===== rtl/text_console_buffer_core.sv =====
// Set cursor and no-op transactions go from decode to done; put/get/print pass through a cell access state.
// A new transaction is accepted only once the previous result is loaded; clear writes one cell per cycle.
// Shift: each direction phase moves every cell, after an edge line save when roll is set; one store port.
// Reset: cursor to 0,0, columns 80, rows 25; then a clearing sweep writes spaces to all
// MAX_COLS*MAX_ROWS cells of the store while req_stall stays high.
module text_console_buffer_core #(
	parameter int MAX_COLS = tcb_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = tcb_pkg::MAX_ROWS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  tcb_pkg::req_t                    req,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output tcb_pkg::rsp_t                    rsp,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [tcb_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [tcb_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [tcb_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready
);
	import tcb_pkg::*;

	logic [7:0] columns_q;
	logic [6:0] rows_q;
	logic       reg_sel;

	// Register file
	assign pready  = 1'b1;
	assign reg_sel = paddr[APB_ADDR_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= COLUMNS_RESET;
			rows_q    <= ROWS_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_sel)
				REG_COLUMNS: columns_q <= pwdata[7:0];
				REG_ROWS:    rows_q    <= pwdata[6:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_COLUMNS: prdata = APB_DATA_W'(columns_q);
			REG_ROWS:    prdata = APB_DATA_W'(rows_q);
		endcase
	end

	// Controller and datapath
	ctl_t ctl;
	sts_t sts;
	rsp_t result;
	logic idle, out_load, out_free;

	assign req_stall = !idle;
	assign out_free  = !rsp_valid || !rsp_stall;

	tcb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.out_free  (out_free),
		.sts       (sts),
		.ctl       (ctl),
		.idle      (idle),
		.out_load  (out_load)
	);

	tcb_dp #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.columns (columns_q),
		.rows    (rows_q),
		.ctl     (ctl),
		.sts     (sts),
		.result  (result)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (out_load) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) rsp <= result;
	end

endmodule

// ===== rtl/tcb_checker.sv =====
module tcb_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input tcb_pkg::rsp_t rsp
);
	import tcb_pkg::*;

	logic       req_acc, rsp_acc;
	logic [1:0] pend_q;

	assign req_acc = req_valid && !req_stall;
	assign rsp_acc = rsp_valid && !rsp_stall;

	// Transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else if (req_acc && !rsp_acc) begin
			pend_q <= pend_q + 2'd1;
		end else if (rsp_acc && !req_acc) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	// A held result does not change
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// Every result belongs to an accepted transaction
	a_rsp_owned: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("result without an accepted transaction");

	// At most one in the output register and one in work
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many transactions in flight");

	// One transaction at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> req_stall)
		else $error("request accepted back to back");

endmodule

bind text_console_buffer_core tcb_checker u_tcb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
